// File: hdl/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// File: hdl/htd_pkg.sv
// Types, constants and the tree table of the Huffman tree-table decoder.
package htd_pkg;

    localparam int unsigned ROM_ENTRIES = 102;
    localparam logic [7:0] NODE_FLAG = 8'h80;
    localparam logic [7:0] LINK_MASK = 8'h7F;

    // Entry 0 sits in the most significant byte.
    localparam logic [0:ROM_ENTRIES-1][7:0] TREE_ROM = {
        8'ha1, 8'h81, 8'h8b, 8'h81, 8'h5e, 8'h81, 8'h81, 8'h45,
        8'h81, 8'h52, 8'h81, 8'h44, 8'h81, 8'h56, 8'h4b, 8'h81,
        8'h81, 8'h30, 8'h81, 8'h2d, 8'h81, 8'h4a, 8'h36, 8'h38,
        8'h81, 8'h20, 8'h83, 8'h81, 8'h81, 8'h48, 8'h59, 8'h43,
        8'h82, 8'h81, 8'h4d, 8'h57, 8'h81, 8'h2e, 8'h81, 8'h42,
        8'h84, 8'h81, 8'h31, 8'h81, 8'h5a, 8'h81, 8'h34, 8'h33,
        8'h86, 8'h81, 8'h51, 8'h81, 8'h81, 8'h32, 8'h81, 8'h25,
        8'h2b, 8'h81, 8'h23, 8'h28, 8'h81, 8'h3f, 8'h39, 8'h81,
        8'h37, 8'h2a, 8'h86, 8'h81, 8'h84, 8'h81, 8'h54, 8'h81,
        8'h81, 8'h4c, 8'h50, 8'h46, 8'h53, 8'h4f, 8'h82, 8'h81,
        8'h4e, 8'h41, 8'h49, 8'h81, 8'h81, 8'h55, 8'h81, 8'h47,
        8'h2c, 8'h81, 8'h81, 8'h58, 8'h27, 8'h81, 8'h81, 8'h21,
        8'h35, 8'h81, 8'h26, 8'h81, 8'h29, 8'h2f
    };

    // Entries beyond the stored table read as zero.
    function automatic logic [7:0] tree_entry(input logic [6:0] idx);
        logic [7:0] value;
        value = 8'h00;
        if (32'(idx) < ROM_ENTRIES)
        begin
            value = TREE_ROM[idx];
        end
        return value;
    endfunction

    typedef struct packed {
        logic       load;
        logic       first;
        logic       step;
        logic [2:0] bit_sel;
    } htd_cmd_t;

    typedef struct packed {
        logic active;
        logic out_free;
    } htd_status_t;

endpackage

// File: hdl/huffman_tree_table_decoder.sv
// Huffman tree-table decoder: a first byte walks one bit, any other byte up to eight.
// The byte is loaded first, then one table lookup per bit; the tree walk sets the rate.
// A step waits while the output register holds a character that is not taken.
// No new byte is taken until the current one is through; a character appears in the cycle after its bit step.
// rst_n clears the walk state, the controller and the output valid asynchronously.
`include "assert_macros.svh"

module huffman_tree_table_decoder
    import htd_pkg::*;
#(
    parameter int unsigned TABLE_BYTES = 102
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // char_count [7:0], data_byte [15:8]
    input  logic        s_tuser,   // first_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // character [6:0], zero [7]
    output logic        m_tlast,
    output logic        m_tuser    // bad_code
);

    htd_cmd_t    cmd;
    htd_status_t status;
    logic [6:0]  out_char;

    htd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_first (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    htd_datapath #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .char_count (s_tdata[7:0]),
        .data_byte  (s_tdata[15:8]),
        .status     (status),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_char   (out_char),
        .out_last   (m_tlast),
        .out_bad    (m_tuser)
    );

    assign m_tdata = {1'b0, out_char};

    // An error result always ends the message and carries no character.
    `ASSERT_IMPLIES(a_bad_is_last, clk, rst_n, m_tvalid && m_tuser, m_tlast && (m_tdata == 8'd0))
    // A bit step never overwrites a result that has not been taken.
    `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, cmd.step, !m_tvalid || m_tready)
    // No new request is taken while a byte is still being walked.
    `ASSERT_IMPLIES(a_idle_no_step, clk, rst_n, s_tready, !cmd.step)
    // An error result from a step leaves no message in progress.
    `ASSERT_NEXT(a_error_idles, clk, rst_n, cmd.step, !(m_tvalid && m_tuser) || !status.active)

endmodule

// File: hdl/htd_ctrl.sv
// Controller that sequences the bit steps of each accepted byte.
module htd_ctrl
    import htd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_first,
    output logic        in_ready,
    input  htd_status_t status,
    output htd_cmd_t    cmd
);

    typedef enum logic [0:0] {ST_IDLE, ST_RUN} state_t;

    state_t     state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic       first_reg, first_next;
    logic       final_step;

    assign in_ready = (state_reg == ST_IDLE);
    // A first byte gives one bit; other bytes give eight.
    assign final_step = first_reg || (step_reg == 3'd7);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        first_next = first_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cmd.first  = in_first;
                    first_next = in_first;
                    step_next  = 3'd0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!status.active)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.step    = 1'b1;
                    // Bits 6 down to 0 come first, bit 7 last.
                    cmd.bit_sel = final_step ? 3'd7 : 3'd6 - step_reg;
                    if (final_step)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        step_next = step_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 3'd0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            first_reg <= first_next;
        end
    end

endmodule

// File: hdl/htd_datapath.sv
// Datapath: byte register, tree walk state, table lookup and output register.
module htd_datapath
    import htd_pkg::*;
#(
    parameter int unsigned TABLE_BYTES = 102
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  htd_cmd_t    cmd,
    input  logic [7:0]  char_count,
    input  logic [7:0]  data_byte,
    output htd_status_t status,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  out_char,
    output logic        out_last,
    output logic        out_bad
);

    logic [7:0] byte_reg;
    logic [6:0] offset_reg;
    logic [7:0] chars_reg;
    logic       active_reg;
    logic       valid_reg;
    logic [6:0] char_reg;
    logic       last_reg;
    logic       bad_reg;

    logic       cur_bit;
    logic [7:0] idx;
    logic [7:0] entry;
    logic [8:0] next_off;
    logic       idx_bad;
    logic       is_leaf;
    logic       next_bad;
    logic [7:0] chars_dec;
    logic       emit_res;

    assign cur_bit   = byte_reg[cmd.bit_sel];
    assign idx       = {1'b0, offset_reg} + {7'd0, cur_bit};
    assign idx_bad   = idx >= 8'(TABLE_BYTES);
    assign entry     = tree_entry(idx[6:0]);
    assign is_leaf   = (entry & NODE_FLAG) == 8'h00;
    assign next_off  = {2'b00, offset_reg} + {1'b0, entry[6:0], 1'b0};
    assign next_bad  = next_off >= 9'(TABLE_BYTES);
    assign chars_dec = chars_reg - 8'd1;
    // A step emits a result on a leaf or on either kind of table overrun.
    assign emit_res  = cmd.step && active_reg && (idx_bad || is_leaf || next_bad);

    assign status.active   = active_reg;
    assign status.out_free = !valid_reg || out_ready;

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;
    assign out_bad   = bad_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= 7'd0;
            chars_reg  <= 8'd0;
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (emit_res)
            begin
                valid_reg <= 1'b1;
            end
            else if (valid_reg && out_ready)
            begin
                valid_reg <= 1'b0;
            end
            if (cmd.load && cmd.first)
            begin
                offset_reg <= 7'd0;
                chars_reg  <= char_count;
                active_reg <= char_count != 8'd0;
            end
            else if (cmd.step && active_reg)
            begin
                priority if (idx_bad || (!is_leaf && next_bad))
                begin
                    offset_reg <= 7'd0;
                    chars_reg  <= 8'd0;
                    active_reg <= 1'b0;
                end
                else if (is_leaf)
                begin
                    offset_reg <= 7'd0;
                    chars_reg  <= chars_dec;
                    active_reg <= chars_dec != 8'd0;
                end
                else
                begin
                    offset_reg <= next_off[6:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && active_reg)
        begin
            if (idx_bad || (!is_leaf && next_bad))
            begin
                char_reg <= 7'd0;
                last_reg <= 1'b1;
                bad_reg  <= 1'b1;
            end
            else if (is_leaf)
            begin
                char_reg <= entry[6:0];
                last_reg <= chars_dec == 8'd0;
                bad_reg  <= 1'b0;
            end
        end
    end

endmodule

// File: sim/tb_huffman_tree_table_decoder.sv
// Self-checking testbench for the Huffman tree-table decoder, driven over stream handshakes.
`timescale 1ns / 1ps

module tb_huffman_tree_table_decoder
    import htd_pkg::*;
();

    localparam int unsigned TABLE_BYTES = 102;
    localparam int CLK_HALF = 4;
    localparam int RANDOM_REQUESTS = 115;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int FLOOD_REQUESTS = 24;
    localparam int TAIL_CYCLES = 20;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [6:0] code;
        logic       last;
        logic       bad;
    } char_result_t;

    typedef struct packed {
        logic         first;
        logic [7:0]   count;
        logic [7:0]   data;
        logic         typed;
        logic [1:0]   n_typed;
        char_result_t typed_res;
    } stim_row_t;

    localparam char_result_t NO_RES = '{7'h00, 1'b0, 1'b0};
    localparam char_result_t CARET_LAST = '{7'h5e, 1'b1, 1'b0};
    localparam int N_ROWS = 25;

    // Rows that are typed carry their own expectation; the rest go through the predictor.
    localparam stim_row_t DIRECTED_ROWS [0:N_ROWS-1] = '{
        '{1'b0, 8'h00, 8'hff, 1'b1, 2'd0, NO_RES},
        '{1'b0, 8'hff, 8'h00, 1'b1, 2'd0, NO_RES},
        '{1'b1, 8'h00, 8'hff, 1'b1, 2'd0, NO_RES},
        '{1'b0, 8'h00, 8'ha5, 1'b1, 2'd0, NO_RES},
        '{1'b1, 8'h01, 8'h80, 1'b1, 2'd0, NO_RES},
        '{1'b0, 8'h00, 8'h40, 1'b1, 2'd1, CARET_LAST},
        '{1'b1, 8'h03, 8'h00, 1'b0, 2'd0, NO_RES},
        '{1'b0, 8'h00, 8'h00, 1'b0, 2'd0, NO_RES},
        '{1'b0, 8'h00, 8'hff, 1'b0, 2'd0, NO_RES},
        '{1'b0, 8'h00, 8'h5a, 1'b0, 2'd0, NO_RES},
        '{1'b1, 8'hff, 8'hff, 1'b0, 2'd0, NO_RES},
        '{1'b0, 8'h00, 8'hff, 1'b0, 2'd0, NO_RES},
        '{1'b0, 8'h00, 8'h00, 1'b0, 2'd0, NO_RES},
        '{1'b1, 8'h02, 8'h7f, 1'b0, 2'd0, NO_RES},
        '{1'b0, 8'h00, 8'h3c, 1'b0, 2'd0, NO_RES},
        '{1'b0, 8'h00, 8'hc3, 1'b0, 2'd0, NO_RES},
        '{1'b1, 8'h80, 8'h01, 1'b0, 2'd0, NO_RES},
        '{1'b0, 8'h00, 8'h96, 1'b0, 2'd0, NO_RES},
        '{1'b1, 8'h00, 8'h00, 1'b1, 2'd0, NO_RES},
        '{1'b0, 8'h00, 8'h69, 1'b1, 2'd0, NO_RES},
        '{1'b1, 8'h08, 8'h80, 1'b0, 2'd0, NO_RES},
        '{1'b0, 8'h00, 8'haa, 1'b0, 2'd0, NO_RES},
        '{1'b0, 8'h00, 8'h55, 1'b0, 2'd0, NO_RES},
        '{1'b0, 8'h00, 8'he7, 1'b0, 2'd0, NO_RES},
        '{1'b0, 8'h00, 8'h18, 1'b0, 2'd0, NO_RES}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'h0000;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    // Predictor state.
    logic [6:0] walk_offset = '0;
    logic [7:0] chars_remaining = '0;
    logic       msg_active = 1'b0;

    char_result_t expected_chars [$];
    int mismatches = 0;
    int live_requests = 0;
    int messages_started = 0;
    int chars_seen = 0;
    int bad_codes_seen = 0;
    int quiet_cycles = 0;
    int flood_left = 0;
    bit no_idle = 1'b0;
    bit hold_off_armed = 1'b0;

    huffman_tree_table_decoder #(
        .TABLE_BYTES(TABLE_BYTES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #(CLK_HALF) clk = ~clk;

    task automatic push_char(input logic [6:0] code, input logic last, input logic bad,
                             input bit keep);
        char_result_t r;
        r = '{code, last, bad};
        if (keep)
        begin
            expected_chars.push_back(r);
        end
    endtask

    task automatic abort_walk(input bit keep);
        push_char(7'h00, 1'b1, 1'b1, keep);
        msg_active = 1'b0;
        chars_remaining = '0;
        walk_offset = '0;
    endtask

    task automatic walk_tree(input logic bit_val, input bit keep);
        int unsigned idx;
        int unsigned nxt;
        logic [7:0] entry;
        if (!msg_active)
        begin
            return;
        end
        idx = int'(walk_offset) + int'(bit_val);
        if (idx >= TABLE_BYTES || idx >= 128)
        begin
            abort_walk(keep);
            return;
        end
        entry = (idx < ROM_ENTRIES) ? TREE_ROM[idx] : 8'h00;
        if ((entry & NODE_FLAG) == 8'h00)
        begin
            chars_remaining = chars_remaining - 8'd1;
            walk_offset = '0;
            if (chars_remaining == 8'd0)
            begin
                msg_active = 1'b0;
            end
            push_char(entry[6:0], chars_remaining == 8'd0, 1'b0, keep);
            return;
        end
        nxt = int'(walk_offset) + int'(entry & LINK_MASK) * 2;
        if (nxt >= TABLE_BYTES || nxt >= 128)
        begin
            abort_walk(keep);
            return;
        end
        walk_offset = nxt[6:0];
    endtask

    task automatic decode_byte(input logic first, input logic [7:0] count,
                               input logic [7:0] data, input bit keep);
        int b;
        if (first)
        begin
            walk_offset = '0;
            chars_remaining = count;
            msg_active = (count != 8'd0);
            walk_tree(data[7], keep);
        end
        else
        begin
            for (b = 6; b >= 0; b--)
            begin
                walk_tree(data[b], keep);
            end
            walk_tree(data[7], keep);
        end
    endtask

    // Offers one request after a random gap and returns once it has been accepted.
    task automatic send_request(input logic first, input logic [7:0] count,
                                input logic [7:0] data, input stim_row_t row);
        int gap;
        int k;
        gap = (no_idle || flood_left > 0) ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= first;
        s_tdata  <= {data, count};
        do @(posedge clk); while (!s_tready);
        if (first || msg_active)
        begin
            live_requests++;
        end
        if (first)
        begin
            messages_started++;
        end
        if (flood_left > 0)
        begin
            flood_left--;
        end
        decode_byte(first, count, data, !row.typed);
        if (row.typed)
        begin
            for (k = 0; k < int'(row.n_typed); k++)
            begin
                expected_chars.push_back(row.typed_res);
            end
        end
    endtask

    task automatic report_mismatch(input string field, input int got_v, input int exp_v);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", field, got_v, exp_v, $realtime);
        mismatches++;
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        char_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            chars_seen++;
            if (m_tuser)
            begin
                bad_codes_seen++;
            end
            if (expected_chars.size() == 0)
            begin
                report_mismatch("unexpected result", int'(m_tdata), 0);
            end
            else
            begin
                exp_r = expected_chars.pop_front();
                if (m_tdata[6:0] !== exp_r.code)
                begin
                    report_mismatch("character", int'(m_tdata[6:0]), int'(exp_r.code));
                end
                if (m_tlast !== exp_r.last)
                begin
                    report_mismatch("last", int'(m_tlast), int'(exp_r.last));
                end
                if (m_tuser !== exp_r.bad)
                begin
                    report_mismatch("bad_code", int'(m_tuser), int'(exp_r.bad));
                end
            end
        end
    end

    // Watchdog on handshake progress.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired with %0d results outstanding", expected_chars.size());
            $display("huffman_tree_table_decoder regression: fail");
            $finish;
        end
    end

    // Receiver: random stalls per result, and one long hold-off so the block backs up.
    initial
    begin
        int stall;
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 14);
            if (hold_off_armed)
            begin
                hold_off_armed = 1'b0;
                stall = HOLD_OFF_CYCLES;
            end
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin
        int row;
        int kind;
        int max_bytes;
        int nb;
        logic [7:0] count;
        stim_row_t plain;
        plain = '{1'b0, 8'h00, 8'h00, 1'b0, 2'd0, NO_RES};
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        for (row = 0; row < N_ROWS; row++)
        begin
            send_request(DIRECTED_ROWS[row].first, DIRECTED_ROWS[row].count,
                         DIRECTED_ROWS[row].data, DIRECTED_ROWS[row]);
        end

        // Back-to-back requests while the receiver holds off fill the block.
        flood_left = FLOOD_REQUESTS;
        hold_off_armed = 1'b1;
        live_requests = 0;
        while (live_requests < RANDOM_REQUESTS)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 19);
            if (kind < 2)
            begin
                // Noise: a non-first request, ignored when no message is open.
                send_request(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             plain);
            end
            else
            begin
                if (kind < 6)
                begin
                    count = 8'($urandom_range(0, 255));
                    max_bytes = $urandom_range(1, 6);
                end
                else
                begin
                    count = 8'($urandom_range(1, 8));
                    max_bytes = (kind == 19) ? $urandom_range(1, 3) : 1000;
                end
                send_request(1'b1, count, 8'($urandom_range(0, 255)), plain);
                nb = 0;
                while (msg_active && nb < max_bytes)
                begin
                    send_request(1'b0, 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), plain);
                    nb++;
                end
            end
        end
        no_idle = 1'b0;
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (expected_chars.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d directed rows and %0d messages; %0d live random requests.",
                 N_ROWS, messages_started, live_requests);
        $display("Checked %0d results, %0d with bad_code, %0d mismatches.",
                 chars_seen, bad_codes_seen, mismatches);
        if (mismatches == 0 && expected_chars.size() == 0)
        begin
            $display("huffman_tree_table_decoder regression: pass");
        end
        else
        begin
            $display("huffman_tree_table_decoder regression: fail");
        end
        $finish;
    end

endmodule
